// ===== hdl/csta_pkg.sv =====
// Package for the cell shape tensor block: widths, saturation bounds,
// state encodings and the request/response structs of the root/divide unit.
// No dependencies.
`default_nettype none

package csta_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_BITS_DEF   = 24;
    localparam int MAX_VERTICES_DEF = 64;

    // Result field widths
    localparam int MOM_W = 55;
    localparam int XY_W  = 56;
    localparam int ANI_W = 17;

    // Normalized operand width for the anisotropy path
    localparam int NORM_W = 24;
    // Width of (a-d)^2 + 4*b^2
    localparam int DD_W   = 51;

    // Root and divide unit sizing
    localparam int SQRT_SHIFT = 12;
    localparam int DIV_SHIFT  = 10;
    localparam int ROOT_W     = 32;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 3;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = ROOT_W + DIV_SHIFT;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Saturation bound of the moments and the Q1.16 value of one
    localparam logic [MOM_W-1:0] SAT_POS = {1'b1, {(MOM_W-1){1'b0}}};
    localparam logic [ANI_W-1:0] ONE_Q16 = {1'b1, {(ANI_W-1){1'b0}}};

    // Top-level sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_DRAIN,
        ST_TRACE,
        ST_NORM,
        ST_DIFF,
        ST_SQ1,
        ST_SQ2,
        ST_SQW,
        ST_RSTART,
        ST_ROOT,
        ST_EMIT
    } t_state;

    // Destination of a product leaving the shared multiplier
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_XX,
        ACC_YY,
        ACC_XY,
        ACC_DSET,
        ACC_DADD
    } t_acc_op;

    // Root/divide unit phases
    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ROOT,
        RD_DIV
    } t_rd_phase;

    typedef struct packed {
        logic              start;
        logic [DD_W-1:0]   dd;
        logic [NORM_W-1:0] divisor;
    } t_rd_req;

    typedef struct packed {
        logic             done;
        logic [ANI_W-1:0] aniso;
    } t_rd_rsp;

endpackage

`default_nettype wire

// ===== hdl/csta_if.sv =====
// Channel interfaces of the cell shape tensor block: vertex input and
// tensor result output, each with valid/ready. Depends on csta_pkg.
`default_nettype none

interface csta_vtx_if #(
    parameter int COORD_BITS = csta_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic                         last_vertex;

    modport source (
        output valid, vertex_x, vertex_y, center_x, center_y, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, vertex_x, vertex_y, center_x, center_y, last_vertex,
        output ready
    );
endinterface

interface csta_res_if;
    logic                                 valid;
    logic                                 ready;
    logic        [csta_pkg::MOM_W-1:0]    moment_xx;
    logic        [csta_pkg::MOM_W-1:0]    moment_yy;
    logic signed [csta_pkg::XY_W-1:0]     moment_xy;
    logic        [csta_pkg::ANI_W-1:0]    anisotropy;
    logic                                 degenerate;

    modport source (
        output valid, moment_xx, moment_yy, moment_xy, anisotropy, degenerate,
        input  ready
    );
    modport sink (
        input  valid, moment_xx, moment_yy, moment_xy, anisotropy, degenerate,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/csta_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on csta_pkg for the default width.
`default_nettype none

module csta_mul #(
    parameter int WIDTH = csta_pkg::NORM_W + 1
) (
    input  logic                 i_clk,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    output logic [2*WIDTH-1:0]   o_p
);

    logic [2*WIDTH-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/csta_rootdiv.sv =====
// Iterative square root then restoring divide, one bit per cycle on a single
// shared compare-subtract. Computes min(1.0, floor(sqrt(dd*2^12)*2^10 / divisor)), or zero for a zero divisor.
// Depends on csta_pkg.
`default_nettype none

module csta_rootdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csta_pkg::t_rd_req i_req,
    output csta_pkg::t_rd_rsp o_rsp
);

    localparam int RAD_W  = csta_pkg::RAD_W;
    localparam int REM_W  = csta_pkg::REM_W;
    localparam int ROOT_W = csta_pkg::ROOT_W;
    localparam int NORM_W = csta_pkg::NORM_W;
    localparam int ANI_W  = csta_pkg::ANI_W;
    localparam int STEP_W = csta_pkg::STEP_W;

    csta_pkg::t_rd_phase r_phase, n_phase;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [RAD_W-1:0]    r_rad, n_rad;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic                r_ovf, n_ovf;
    logic [NORM_W-1:0]   r_div, n_div;
    logic                r_done, n_done;
    logic [ANI_W-1:0]    r_q, n_q;

    logic [REM_W-1:0]    w_op_a;
    logic [REM_W-1:0]    w_op_b;
    logic [REM_W:0]      w_sub;
    logic                w_ge;
    logic [ROOT_W-1:0]   w_root_step;
    logic                w_last;

    // Operand select for the shared compare-subtract
    always_comb begin
        case (r_phase)
            csta_pkg::RD_ROOT: begin
                w_op_a = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
                w_op_b = {1'b0, r_root, 2'b01};
            end
            csta_pkg::RD_DIV: begin
                w_op_a = {{(REM_W-NORM_W-1){1'b0}}, r_rem[NORM_W-1:0], r_rad[RAD_W-1]};
                w_op_b = REM_W'(r_div);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_sub       = {1'b0, w_op_a} - {1'b0, w_op_b};
    assign w_ge        = ~w_sub[REM_W];
    assign w_root_step = {r_root[ROOT_W-2:0], w_ge};
    assign w_last      = (r_phase == csta_pkg::RD_ROOT)
                       ? (r_cnt == STEP_W'(csta_pkg::ROOT_STEPS - 1))
                       : (r_cnt == STEP_W'(csta_pkg::DIV_STEPS - 1));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            csta_pkg::RD_IDLE: begin
                if (i_req.start) begin
                    n_phase = csta_pkg::RD_ROOT;
                end
            end
            csta_pkg::RD_ROOT: begin
                if (w_last) begin
                    n_phase = csta_pkg::RD_DIV;
                end
            end
            csta_pkg::RD_DIV: begin
                if (w_last) begin
                    n_phase = csta_pkg::RD_IDLE;
                end
            end
            default: n_phase = csta_pkg::RD_IDLE;
        endcase
    end

    // Datapath for each phase
    always_comb begin
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_ovf  = r_ovf;
        n_div  = r_div;
        n_done = 1'b0;
        n_q    = r_q;
        case (r_phase)
            csta_pkg::RD_IDLE: begin
                if (i_req.start) begin
                    n_rad  = RAD_W'({i_req.dd, {csta_pkg::SQRT_SHIFT{1'b0}}});
                    n_rem  = '0;
                    n_root = '0;
                    n_ovf  = 1'b0;
                    n_cnt  = '0;
                    n_div  = i_req.divisor;
                end
            end
            csta_pkg::RD_ROOT: begin
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                n_rem  = w_ge ? w_sub[REM_W-1:0] : w_op_a;
                n_root = w_root_step;
                n_cnt  = r_cnt + 1'b1;
                // Hand the root over as the dividend, scaled by the low zeros
                if (w_last) begin
                    n_rad  = {w_root_step, {(RAD_W-ROOT_W){1'b0}}};
                    n_rem  = '0;
                    n_root = '0;
                    n_ovf  = 1'b0;
                    n_cnt  = '0;
                end
            end
            csta_pkg::RD_DIV: begin
                n_rad  = {r_rad[RAD_W-2:0], 1'b0};
                n_rem  = w_ge ? w_sub[REM_W-1:0] : w_op_a;
                n_root = w_root_step;
                n_ovf  = r_ovf | r_root[ROOT_W-1];
                n_cnt  = r_cnt + 1'b1;
                // Clamp the quotient to one; a zero divisor yields zero
                if (w_last) begin
                    n_done = 1'b1;
                    if (r_div == '0) begin
                        n_q = '0;
                    end else if (n_ovf || (n_root > ROOT_W'(csta_pkg::ONE_Q16))) begin
                        n_q = csta_pkg::ONE_Q16;
                    end else begin
                        n_q = n_root[ANI_W-1:0];
                    end
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= csta_pkg::RD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_ovf  <= n_ovf;
        r_div  <= n_div;
        r_q    <= n_q;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.aniso = r_q;

endmodule

`default_nettype wire

// ===== hdl/cell_shape_tensor_anisotropy.sv =====
// Top level of the cell shape tensor block: sequencer, accumulators and
// result register. Depends on csta_pkg, csta_if, csta_mul and csta_rootdiv.
//
// Vertices of one cell arrive one transaction at a time with the cell centre;
// the block accumulates the saturating second moments xx, yy and xy of the
// offsets and, on the vertex flagged last, returns the tensor with the
// anisotropy (largest minus smallest eigenvalue over their sum, Q1.16) and a
// degenerate flag for a zero trace, then clears for the next cell. One
// multiplier is shared by all products, so the input is held off while the
// three products of a vertex run after its accept cycle. A last vertex also
// runs the normalizing shift (one bit a cycle, until the trace fits 24 bits),
// the two squares of the discriminant and a bit-serial square root followed
// by a bit-serial divide, all with the input held off; a zero trace skips
// the squares, root and divide. The result then waits for the previous one to
// be taken. Vertices past MAX_VERTICES in one cell are not accumulated.
`default_nettype none

module cell_shape_tensor_anisotropy #(
    parameter int MAX_VERTICES = csta_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = csta_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csta_vtx_if.sink   i_vtx,
    csta_res_if.source o_res
);

    localparam int MOM_W  = csta_pkg::MOM_W;
    localparam int XY_W   = csta_pkg::XY_W;
    localparam int ANI_W  = csta_pkg::ANI_W;
    localparam int NORM_W = csta_pkg::NORM_W;
    localparam int DD_W   = csta_pkg::DD_W;
    localparam int MUL_W  = (COORD_BITS + 1 > NORM_W + 1) ? COORD_BITS + 1 : NORM_W + 1;
    localparam int PW     = 2 * MUL_W;
    localparam int UW     = ((PW > MOM_W) ? PW : MOM_W) + 1;
    localparam int SW     = UW + 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    localparam logic signed [SW-1:0] XY_HI = SW'(csta_pkg::SAT_POS);
    localparam logic signed [SW-1:0] XY_LO = -XY_HI;

    // Sequencer
    csta_pkg::t_state  r_state, n_state;

    // Current vertex
    logic [COORD_BITS:0]        r_ax, r_ay;
    logic                       r_sx, r_sy;
    logic                       r_last;
    logic                       r_use;
    logic [CNT_W-1:0]           r_vcount;

    // Multiplier and its destination tag
    logic [MUL_W-1:0]           w_mul_a, w_mul_b;
    logic [PW-1:0]              w_prod;
    csta_pkg::t_acc_op          w_tag, r_tag;
    logic                       w_tag_neg, r_tag_neg;

    // Accumulators
    logic [MOM_W-1:0]           r_acc_xx, r_acc_yy;
    logic signed [XY_W-1:0]     r_acc_xy;
    logic [UW-1:0]              w_sum_u;
    logic [MOM_W-1:0]           w_sat_u;
    logic signed [SW-1:0]       w_prod_s, w_sum_s;
    logic [XY_W-1:0]            w_sat_s;

    // Anisotropy working registers
    logic [MOM_W:0]             r_t;
    logic [MOM_W-1:0]           r_a, r_d, r_b;
    logic [NORM_W-1:0]          r_diff;
    logic [NORM_W:0]            r_bc;
    logic [NORM_W-1:0]          r_div;
    logic [DD_W-1:0]            r_dd;
    logic                       r_degen;
    logic [ANI_W-1:0]           r_aniso;

    // Root/divide unit
    csta_pkg::t_rd_req          w_rd_req;
    csta_pkg::t_rd_rsp          w_rd_rsp;

    // Result register
    logic                       r_out_valid;
    logic [MOM_W-1:0]           r_out_xx, r_out_yy;
    logic signed [XY_W-1:0]     r_out_xy;
    logic [ANI_W-1:0]           r_out_aniso;
    logic                       r_out_degen;

    logic                       w_ready;
    logic                       w_accept;
    logic                       w_out_free;
    logic                       w_emit;
    logic signed [COORD_BITS:0] w_dx, w_dy;

    assign w_accept   = i_vtx.valid && w_ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_emit     = (r_state == csta_pkg::ST_EMIT) && w_out_free;

    // Offsets of the incoming vertex
    assign w_dx = {i_vtx.vertex_x[COORD_BITS-1], i_vtx.vertex_x}
                - {i_vtx.center_x[COORD_BITS-1], i_vtx.center_x};
    assign w_dy = {i_vtx.vertex_y[COORD_BITS-1], i_vtx.vertex_y}
                - {i_vtx.center_y[COORD_BITS-1], i_vtx.center_y};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            csta_pkg::ST_IDLE:   if (w_accept) n_state = csta_pkg::ST_XX;
            csta_pkg::ST_XX:     n_state = csta_pkg::ST_YY;
            csta_pkg::ST_YY:     n_state = csta_pkg::ST_XY;
            csta_pkg::ST_XY:     n_state = r_last ? csta_pkg::ST_DRAIN : csta_pkg::ST_IDLE;
            csta_pkg::ST_DRAIN:  n_state = csta_pkg::ST_TRACE;
            csta_pkg::ST_TRACE:  n_state = csta_pkg::ST_NORM;
            csta_pkg::ST_NORM: begin
                if (r_t == '0) begin
                    n_state = csta_pkg::ST_EMIT;
                end else if (r_t[MOM_W:NORM_W] == '0) begin
                    n_state = csta_pkg::ST_DIFF;
                end
            end
            csta_pkg::ST_DIFF:   n_state = csta_pkg::ST_SQ1;
            csta_pkg::ST_SQ1:    n_state = csta_pkg::ST_SQ2;
            csta_pkg::ST_SQ2:    n_state = csta_pkg::ST_SQW;
            csta_pkg::ST_SQW:    n_state = csta_pkg::ST_RSTART;
            csta_pkg::ST_RSTART: n_state = csta_pkg::ST_ROOT;
            csta_pkg::ST_ROOT:   if (w_rd_rsp.done) n_state = csta_pkg::ST_EMIT;
            csta_pkg::ST_EMIT:   if (w_out_free) n_state = csta_pkg::ST_IDLE;
            default:             n_state = csta_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, multiplier operands and tag, unit request
    always_comb begin
        w_ready          = 1'b0;
        w_mul_a          = '0;
        w_mul_b          = '0;
        w_tag            = csta_pkg::ACC_NONE;
        w_tag_neg        = 1'b0;
        w_rd_req.start   = 1'b0;
        w_rd_req.dd      = r_dd;
        w_rd_req.divisor = r_div;
        case (r_state)
            csta_pkg::ST_IDLE: begin
                w_ready = 1'b1;
            end
            csta_pkg::ST_XX: begin
                w_mul_a = MUL_W'(r_ax);
                w_mul_b = MUL_W'(r_ax);
                w_tag   = r_use ? csta_pkg::ACC_XX : csta_pkg::ACC_NONE;
            end
            csta_pkg::ST_YY: begin
                w_mul_a = MUL_W'(r_ay);
                w_mul_b = MUL_W'(r_ay);
                w_tag   = r_use ? csta_pkg::ACC_YY : csta_pkg::ACC_NONE;
            end
            csta_pkg::ST_XY: begin
                w_mul_a   = MUL_W'(r_ax);
                w_mul_b   = MUL_W'(r_ay);
                w_tag     = r_use ? csta_pkg::ACC_XY : csta_pkg::ACC_NONE;
                w_tag_neg = r_sx ^ r_sy;
            end
            csta_pkg::ST_SQ1: begin
                w_mul_a = MUL_W'(r_diff);
                w_mul_b = MUL_W'(r_diff);
                w_tag   = csta_pkg::ACC_DSET;
            end
            csta_pkg::ST_SQ2: begin
                w_mul_a = MUL_W'(r_bc);
                w_mul_b = MUL_W'(r_bc);
                w_tag   = csta_pkg::ACC_DADD;
            end
            csta_pkg::ST_RSTART: begin
                w_rd_req.start = 1'b1;
            end
            default: begin
                w_ready = 1'b0;
            end
        endcase
    end

    csta_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    csta_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rd_req),
        .o_rsp   (w_rd_rsp)
    );

    // Saturating adds of the product leaving the multiplier
    always_comb begin
        w_sum_u  = UW'((r_tag == csta_pkg::ACC_XX) ? r_acc_xx : r_acc_yy) + UW'(w_prod);
        w_sat_u  = (w_sum_u > UW'(csta_pkg::SAT_POS)) ? csta_pkg::SAT_POS
                                                      : w_sum_u[MOM_W-1:0];
        w_prod_s = SW'(w_prod);
        w_sum_s  = SW'(r_acc_xy) + (r_tag_neg ? -w_prod_s : w_prod_s);
        if (w_sum_s > XY_HI) begin
            w_sat_s = XY_HI[XY_W-1:0];
        end else if (w_sum_s < XY_LO) begin
            w_sat_s = XY_LO[XY_W-1:0];
        end else begin
            w_sat_s = w_sum_s[XY_W-1:0];
        end
    end

    // Control state, accumulators and vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csta_pkg::ST_IDLE;
            r_tag       <= csta_pkg::ACC_NONE;
            r_tag_neg   <= 1'b0;
            r_acc_xx    <= '0;
            r_acc_yy    <= '0;
            r_acc_xy    <= '0;
            r_vcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tag     <= w_tag;
            r_tag_neg <= w_tag_neg;
            // Count accepted vertices, stop at the limit
            if (w_accept && (r_vcount < CNT_W'(MAX_VERTICES))) begin
                r_vcount <= r_vcount + 1'b1;
            end
            // Load the next result and clear the cell, else drop a taken result
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_acc_xx    <= '0;
                r_acc_yy    <= '0;
                r_acc_xy    <= '0;
                r_vcount    <= '0;
            end else begin
                if (o_res.ready) begin
                    r_out_valid <= 1'b0;
                end
                case (r_tag)
                    csta_pkg::ACC_XX: r_acc_xx <= w_sat_u;
                    csta_pkg::ACC_YY: r_acc_yy <= w_sat_u;
                    csta_pkg::ACC_XY: r_acc_xy <= w_sat_s;
                    default:          r_acc_xx <= r_acc_xx;
                endcase
            end
        end
    end

    // Vertex capture and anisotropy datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax   <= w_dx[COORD_BITS] ? -w_dx : w_dx;
            r_ay   <= w_dy[COORD_BITS] ? -w_dy : w_dy;
            r_sx   <= w_dx[COORD_BITS];
            r_sy   <= w_dy[COORD_BITS];
            r_last <= i_vtx.last_vertex;
            r_use  <= r_vcount < CNT_W'(MAX_VERTICES);
        end
        case (r_tag)
            csta_pkg::ACC_DSET: r_dd <= DD_W'(w_prod);
            csta_pkg::ACC_DADD: r_dd <= r_dd + (DD_W'(w_prod) << 2);
            default:            r_dd <= r_dd;
        endcase
        case (r_state)
            csta_pkg::ST_TRACE: begin
                r_t     <= (MOM_W + 1)'(r_acc_xx) + (MOM_W + 1)'(r_acc_yy);
                r_a     <= r_acc_xx;
                r_d     <= r_acc_yy;
                r_b     <= MOM_W'(r_acc_xy[XY_W-1] ? -r_acc_xy : r_acc_xy);
                r_degen <= 1'b0;
            end
            csta_pkg::ST_NORM: begin
                // Shift everything right until the trace fits the normalized width
                if (r_t == '0) begin
                    r_degen <= 1'b1;
                    r_aniso <= '0;
                end else if (r_t[MOM_W:NORM_W] != '0) begin
                    r_t <= r_t >> 1;
                    r_a <= r_a >> 1;
                    r_d <= r_d >> 1;
                    r_b <= r_b >> 1;
                end
            end
            csta_pkg::ST_DIFF: begin
                r_diff <= (r_a[NORM_W-1:0] >= r_d[NORM_W-1:0])
                        ? r_a[NORM_W-1:0] - r_d[NORM_W-1:0]
                        : r_d[NORM_W-1:0] - r_a[NORM_W-1:0];
                r_bc   <= (r_b > MOM_W'({1'b1, {NORM_W{1'b0}}}))
                        ? {1'b1, {NORM_W{1'b0}}} : r_b[NORM_W:0];
                r_div  <= r_a[NORM_W-1:0] + r_d[NORM_W-1:0];
            end
            csta_pkg::ST_ROOT: begin
                if (w_rd_rsp.done) begin
                    r_aniso <= w_rd_rsp.aniso;
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
        if (w_emit) begin
            r_out_xx    <= r_acc_xx;
            r_out_yy    <= r_acc_yy;
            r_out_xy    <= r_acc_xy;
            r_out_aniso <= r_aniso;
            r_out_degen <= r_degen;
        end
    end

    assign i_vtx.ready      = w_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.moment_xx  = r_out_xx;
    assign o_res.moment_yy  = r_out_yy;
    assign o_res.moment_xy  = r_out_xy;
    assign o_res.anisotropy = r_out_aniso;
    assign o_res.degenerate = r_out_degen;

    // An accepted vertex always starts the product sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vtx.valid && i_vtx.ready) |=> (r_state == csta_pkg::ST_XX))
        else $error("accepted vertex did not start the product sequence");

    // Moment accumulators never exceed the saturation bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_xx <= csta_pkg::SAT_POS) && (r_acc_yy <= csta_pkg::SAT_POS))
        else $error("moment accumulator above saturation bound");

    // Vertex count stays within the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past limit");

    // Emitting a result loads the output and clears the cell state
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_out_valid && (r_acc_xx == '0) && (r_acc_yy == '0)
                    && (r_acc_xy == '0) && (r_vcount == '0)))
        else $error("emit did not load result or clear accumulators");

    // The root/divide unit finishes only while the sequencer waits for it
    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_rsp.done |-> (r_state == csta_pkg::ST_ROOT))
        else $error("root/divide result outside the wait state");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for cell_shape_tensor_anisotropy: streams polygon cells through the
// vertex channel and checks every tensor result against a built-in predictor.
// Depends on csta_pkg, csta_if and the block's RTL.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = csta_pkg::COORD_BITS_DEF;
    localparam int MAX_VERTS    = csta_pkg::MAX_VERTICES_DEF;
    localparam int TARGET_ITEMS = 1500;
    localparam int QUIET_ITEMS  = 1300;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 1000000;

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum {CELL_NEAR, CELL_WIDE, CELL_FLAT} cell_kind_t;

    typedef struct {
        logic        [csta_pkg::MOM_W-1:0] xx;
        logic        [csta_pkg::MOM_W-1:0] yy;
        logic signed [csta_pkg::XY_W-1:0]  xy;
        logic        [csta_pkg::ANI_W-1:0] ani;
        logic                              deg;
    } cell_tensor_t;

    // Shape tensor predictor and result comparison
    class shape_tensor_board;
        logic [63:0]  sum_xx;
        logic [63:0]  sum_yy;
        longint       sum_xy;
        int           vert_cnt;
        cell_tensor_t cell_tensors[$];
        int           mismatches;

        function new();
            sum_xx     = 0;
            sum_yy     = 0;
            sum_xy     = 0;
            vert_cnt   = 0;
            mismatches = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] val);
            logic [63:0] x;
            logic [63:0] res;
            logic [63:0] bitv;
            x    = val;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        // Normalize the trace below 2^24, then root of the discriminant over trace
        function logic [csta_pkg::ANI_W-1:0] anisotropy_q16(logic [63:0] xx, logic [63:0] yy,
                                                            longint xy);
            logic [63:0] t;
            logic [63:0] a;
            logic [63:0] d;
            logic [63:0] b;
            logic [63:0] diff;
            logic [63:0] dd;
            logic [63:0] r;
            logic [63:0] q;
            int          k;
            t = xx + yy;
            k = 0;
            while ((t >> k) >= (64'd1 << csta_pkg::NORM_W)) k++;
            a = xx >> k;
            d = yy >> k;
            b = (xy < 0) ? 64'(-xy) : 64'(xy);
            b = b >> k;
            if (b > (64'd1 << csta_pkg::NORM_W)) b = 64'd1 << csta_pkg::NORM_W;
            diff = (a >= d) ? a - d : d - a;
            dd   = diff * diff + 4 * b * b;
            r    = int_sqrt(dd << csta_pkg::SQRT_SHIFT);
            if (a + d == 0) return '0;
            q = (r << csta_pkg::DIV_SHIFT) / (a + d);
            if (q > 64'(csta_pkg::ONE_Q16)) q = 64'(csta_pkg::ONE_Q16);
            return q[csta_pkg::ANI_W-1:0];
        endfunction

        // Accumulate one accepted vertex; close the cell on the last flag
        function void add_vertex(logic signed [CW-1:0] vx, logic signed [CW-1:0] vy,
                                 logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                 logic last);
            longint       dx;
            longint       dy;
            longint       sat;
            cell_tensor_t tens;
            sat = longint'(64'(csta_pkg::SAT_POS));
            if (vert_cnt < MAX_VERTS) begin
                dx = longint'(vx) - longint'(cx);
                dy = longint'(vy) - longint'(cy);
                sum_xx = sum_xx + 64'(dx * dx);
                if (sum_xx > 64'(sat)) sum_xx = 64'(sat);
                sum_yy = sum_yy + 64'(dy * dy);
                if (sum_yy > 64'(sat)) sum_yy = 64'(sat);
                sum_xy = sum_xy + dx * dy;
                if (sum_xy > sat) sum_xy = sat;
                if (sum_xy < -sat) sum_xy = -sat;
                vert_cnt++;
            end
            if (last) begin
                tens.xx  = sum_xx[csta_pkg::MOM_W-1:0];
                tens.yy  = sum_yy[csta_pkg::MOM_W-1:0];
                tens.xy  = sum_xy[csta_pkg::XY_W-1:0];
                tens.deg = (sum_xx + sum_yy == 0);
                tens.ani = tens.deg ? '0 : anisotropy_q16(sum_xx, sum_yy, sum_xy);
                cell_tensors.insert(cell_tensors.size(), tens);
                sum_xx   = 0;
                sum_yy   = 0;
                sum_xy   = 0;
                vert_cnt = 0;
            end
        endfunction

        // Compare one accepted result with the oldest cell tensor
        function void check_tensor(logic [csta_pkg::MOM_W-1:0] xx,
                                   logic [csta_pkg::MOM_W-1:0] yy,
                                   logic signed [csta_pkg::XY_W-1:0] xy,
                                   logic [csta_pkg::ANI_W-1:0] ani, logic deg);
            cell_tensor_t tens;
            if (cell_tensors.size() == 0) begin
                $error("tensor result with no cell pending");
                mismatches++;
                return;
            end
            tens = cell_tensors.pop_front();
            if (xx !== tens.xx) begin
                $error("moment_xx: expected %0d, actual %0d", tens.xx, xx);
                mismatches++;
            end
            if (yy !== tens.yy) begin
                $error("moment_yy: expected %0d, actual %0d", tens.yy, yy);
                mismatches++;
            end
            if (xy !== tens.xy) begin
                $error("moment_xy: expected %0d, actual %0d", tens.xy, xy);
                mismatches++;
            end
            if (ani !== tens.ani) begin
                $error("anisotropy: expected %0d, actual %0d", tens.ani, ani);
                mismatches++;
            end
            if (deg !== tens.deg) begin
                $error("degenerate: expected %0d, actual %0d", tens.deg, deg);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return cell_tensors.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csta_vtx_if vtx_if ();
    csta_res_if res_if ();

    cell_shape_tensor_anisotropy DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_if.sink),
        .o_res   (res_if.source)
    );

    shape_tensor_board board;
    int   items_sent  = 0;
    int   cycle_count = 0;
    bit   gaps_on     = 1;
    bit   stalls_on   = 1;
    bit   quiet_tail  = 0;

    // Free-running clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Record accepted transactions on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && vtx_if.valid && vtx_if.ready) begin
            board.add_vertex(vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.center_x,
                             vtx_if.center_y, vtx_if.last_vertex);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_tensor(res_if.moment_xx, res_if.moment_yy, res_if.moment_xy,
                               res_if.anisotropy, res_if.degenerate);
        end
    end

    // Drive result ready with random stall bursts
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Present one vertex and hold it until the transaction completes
    task automatic push_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
                               input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                               input logic last);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            vtx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        vtx_if.valid       <= 1'b1;
        vtx_if.vertex_x    <= vx;
        vtx_if.vertex_y    <= vy;
        vtx_if.center_x    <= cx;
        vtx_if.center_y    <= cy;
        vtx_if.last_vertex <= last;
        do @(posedge i_clk); while (!(vtx_if.valid && vtx_if.ready));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send one random cell: mostly ordinary polygons, some long or broken ones
    task automatic send_random_cell();
        int                     n;
        int                     r;
        int                     mag;
        int                     offx;
        int                     offy;
        cell_kind_t             kind;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [CW-1:0]   vx;
        logic signed [CW-1:0]   vy;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            kind = CELL_WIDE;
            n    = $urandom_range(MAX_VERTS - 4, MAX_VERTS + 8);
        end else if (r < 11) begin
            kind = CELL_FLAT;
            n    = $urandom_range(1, 3);
        end else if (r < 16) begin
            kind = CELL_NEAR;
            n    = $urandom_range(1, 2);
        end else begin
            kind = ($urandom_range(0, 4) == 0) ? CELL_WIDE : CELL_NEAR;
            n    = $urandom_range(3, 8);
        end
        if (!quiet_tail) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
        end
        cx  = $urandom;
        cy  = $urandom;
        mag = $urandom_range(0, CW - 2);
        for (int i = 0; i < n; i++) begin
            case (kind)
                CELL_WIDE: begin
                    vx = $urandom;
                    vy = $urandom;
                end
                CELL_FLAT: begin
                    vx = cx;
                    vy = cy;
                end
                default: begin
                    offx = int'($urandom & ((32'd1 << (mag + 1)) - 1)) - (1 << mag);
                    offy = int'($urandom & ((32'd1 << (mag + 1)) - 1)) - (1 << mag);
                    vx   = cx + CW'(offx);
                    vy   = cy + CW'(offy);
                end
            endcase
            push_vertex(vx, vy, cx, cy, i == n - 1);
        end
    endtask

    // Reset, directed cells, random cells, then drain and report
    initial begin
        board              = new();
        i_rst_n            = 1'b0;
        vtx_if.valid       = 1'b0;
        vtx_if.vertex_x    = '0;
        vtx_if.vertex_y    = '0;
        vtx_if.center_x    = '0;
        vtx_if.center_y    = '0;
        vtx_if.last_vertex = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero trace: vertex on the centre
        push_vertex('0, '0, '0, '0, 1'b1);
        // extreme offsets in both directions
        push_vertex(C_MAX, C_MIN, C_MIN, C_MAX, 1'b1);
        push_vertex(C_MIN, C_MAX, C_MAX, C_MIN, 1'b0);
        push_vertex(C_MAX, C_MAX, C_MIN, C_MIN, 1'b1);
        // pure x and pure y offsets: anisotropy of one
        push_vertex(CW'(4096), '0, '0, '0, 1'b1);
        push_vertex('0, -CW'(4096), '0, '0, 1'b1);
        // symmetric square around an off-origin centre: isotropic
        push_vertex(CW'(1000 + 8192), -CW'(2000), CW'(1000), -CW'(2000), 1'b0);
        push_vertex(CW'(1000 - 8192), -CW'(2000), CW'(1000), -CW'(2000), 1'b0);
        push_vertex(CW'(1000), -CW'(2000 - 8192), CW'(1000), -CW'(2000), 1'b0);
        push_vertex(CW'(1000), -CW'(2000 + 8192), CW'(1000), -CW'(2000), 1'b1);
        // skewed triangle
        push_vertex(CW'(30000), CW'(12000), CW'(100), CW'(-50), 1'b0);
        push_vertex(CW'(-9000), CW'(-40000), CW'(100), CW'(-50), 1'b0);
        push_vertex(CW'(500), CW'(70000), CW'(100), CW'(-50), 1'b1);
        // all-ones coordinates against a zero centre
        push_vertex('1, '1, '0, '0, 1'b1);
        // collapsed cell of three vertices on the centre
        push_vertex(C_MIN, C_MAX, C_MIN, C_MAX, 1'b0);
        push_vertex(C_MIN, C_MAX, C_MIN, C_MAX, 1'b0);
        push_vertex(C_MIN, C_MAX, C_MIN, C_MAX, 1'b1);
        // sliver along the diagonal
        push_vertex(CW'(2000000), CW'(2000001), '0, '0, 1'b0);
        push_vertex(-CW'(2000000), -CW'(1999999), '0, '0, 1'b1);

        while (items_sent < TARGET_ITEMS) begin
            if (items_sent >= QUIET_ITEMS) begin
                quiet_tail = 1'b1;
                gaps_on    = 1'b0;
                stalls_on  = 1'b0;
            end
            send_random_cell();
        end
        vtx_if.valid <= 1'b0;

        // Wait for the last tensor, then let the block settle
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
